/* rtl/core/bic_pkg.sv */
package bic_pkg;

  // Fixed field and register widths
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_W     = 12;
  localparam int CNT_W     = 25;
  localparam int SUM_W     = 36;
  localparam int STEP_W    = $clog2(SUM_W);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Register values after reset
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV_X,
    ST_DIV_Y,
    ST_LOAD
  } state_t;

endpackage

/* rtl/core/binary_image_centroid.sv */
// Binary image centroid.
//
// Pixels enter on the pixel channel (pixel_valid / pixel_ready) in raster
// order, one item per clock while a frame streams in. A nonzero pixel counts
// as white; its column and row are summed and counted. The frame size comes
// from frame_width / frame_height, set by cfg_write / cfg_index / cfg_data;
// the user writes them only while the block is idle (the block does not enforce it);
// zero acts as 1, oversize clamps to the MAX_WIDTH / MAX_HEIGHT parameters.
//
// After the last pixel of a frame the block stops taking pixels and runs one
// shared restoring divider, one quotient bit per cycle, for x and then y,
// before the result item is loaded in the load step (a frame with no white
// pixel goes straight to the load step, returns the frame centre and sets
// empty_frame). The divider's dividend is 36 bits wide.
// The result waits in an output register on the result channel
// (result_valid / result_ready); pixels of the next frame are taken while it
// waits, and if the next frame ends before the result is taken the block
// holds in the load step until the register frees.
// Reset (rst, synchronous) clears the position, sums, count and sequencer,
// drops result_valid and restores the frame size to 640 x 480.
module binary_image_centroid
  import bic_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 pixel_valid,
  output logic                 pixel_ready,
  input  logic [7:0]           pixel,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [OUT_W-1:0]     centre_x,
  output logic [OUT_W-1:0]     centre_y,
  output logic [CNT_W-1:0]     white_total,
  output logic                 empty_frame
);

  localparam int CPOS_W = $clog2(MAX_WIDTH);
  localparam int RPOS_W = $clog2(MAX_HEIGHT);
  localparam int SZW_W  = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
  localparam int SZH_W  = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);

  state_t state, state_next;

  logic [CFG_W-1:0]  frame_width, frame_height;
  logic [CPOS_W-1:0] column_pos;
  logic [RPOS_W-1:0] row_pos;
  logic [SUM_W-1:0]  sum_cols, sum_rows;
  logic [CNT_W-1:0]  white_seen;

  // Divider and snapshot registers
  logic [SUM_W-1:0]  dvd;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic [SUM_W-1:0]  snap_rows;
  logic [OUT_W-1:0]  quot_x;
  logic [STEP_W-1:0] step_cnt;
  logic              empty_hold;

  // Effective frame size
  logic [SZW_W-1:0] width_ext, width_eff;
  logic [SZH_W-1:0] height_ext, height_eff;

  assign width_ext  = SZW_W'(frame_width);
  assign height_ext = SZH_W'(frame_height);

  always_comb begin
    if (frame_width == '0) begin
      width_eff = SZW_W'(1);
    end else if (width_ext > SZW_W'(MAX_WIDTH)) begin
      width_eff = SZW_W'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (frame_height == '0) begin
      height_eff = SZH_W'(1);
    end else if (height_ext > SZH_W'(MAX_HEIGHT)) begin
      height_eff = SZH_W'(MAX_HEIGHT);
    end else begin
      height_eff = height_ext;
    end
  end

  // Row and frame end detection
  logic [SZW_W:0] col_inc;
  logic [SZH_W:0] row_inc;
  logic           col_last, row_last, frame_end;

  assign col_inc   = (SZW_W + 1)'(column_pos) + 1'b1;
  assign row_inc   = (SZH_W + 1)'(row_pos) + 1'b1;
  assign col_last  = !(col_inc < {1'b0, width_eff});
  assign row_last  = !(row_inc < {1'b0, height_eff});
  assign frame_end = col_last && row_last;

  // Accumulate the current pixel
  logic             white, pix_take;
  logic [SUM_W-1:0] sum_cols_next, sum_rows_next;
  logic [CNT_W-1:0] white_seen_next;

  assign white    = (pixel != 8'd0);
  assign pix_take = pixel_valid && pixel_ready;

  assign sum_cols_next   = white ? sum_cols + SUM_W'(column_pos) : sum_cols;
  assign sum_rows_next   = white ? sum_rows + SUM_W'(row_pos) : sum_rows;
  assign white_seen_next = white ? white_seen + 1'b1 : white_seen;

  // One restoring division step
  logic [CNT_W:0]   rem_trial, rem_diff;
  logic             fits;
  logic [CNT_W-1:0] rem_step;
  logic [SUM_W-1:0] dvd_step;

  assign rem_trial = {rem, dvd[SUM_W-1]};
  assign fits      = (rem_trial >= {1'b0, divisor});
  assign rem_diff  = rem_trial - {1'b0, divisor};
  assign rem_step  = fits ? rem_diff[CNT_W-1:0] : rem_trial[CNT_W-1:0];
  assign dvd_step  = {dvd[SUM_W-2:0], fits};

  logic step_last, out_free;

  assign step_last = (step_cnt == STEP_W'(SUM_W - 1));
  assign out_free  = !result_valid || result_ready;

  // Sequencer: next state and handshake
  always_comb begin
    state_next  = state;
    pixel_ready = 1'b0;
    unique case (state)
      ST_ACCUM: begin
        pixel_ready = 1'b1;
        if (pixel_valid && frame_end) begin
          state_next = (white_seen_next == '0) ? ST_LOAD : ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (step_last) state_next = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        if (step_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) state_next = ST_ACCUM;
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      if (cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_data;
      if (cfg_index == REG_FRAME_HEIGHT) frame_height <= cfg_data;
    end
  end

  // Position, sums and count
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
      sum_cols   <= '0;
      sum_rows   <= '0;
      white_seen <= '0;
    end else if (pix_take) begin
      if (frame_end) begin
        column_pos <= '0;
        row_pos    <= '0;
        sum_cols   <= '0;
        sum_rows   <= '0;
        white_seen <= '0;
      end else begin
        sum_cols   <= sum_cols_next;
        sum_rows   <= sum_rows_next;
        white_seen <= white_seen_next;
        if (col_last) begin
          column_pos <= '0;
          row_pos    <= row_inc[RPOS_W-1:0];
        end else begin
          column_pos <= col_inc[CPOS_W-1:0];
        end
      end
    end
  end

  // Shared divider: snapshot at frame end, then one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else begin
      unique case (state)
        ST_ACCUM: begin
          step_cnt <= '0;
          if (pix_take && frame_end) begin
            dvd        <= sum_cols_next;
            rem        <= '0;
            divisor    <= white_seen_next;
            snap_rows  <= sum_rows_next;
            empty_hold <= (white_seen_next == '0);
          end
        end
        ST_DIV_X: begin
          if (step_last) begin
            quot_x   <= dvd_step[OUT_W-1:0];
            dvd      <= snap_rows;
            rem      <= '0;
            step_cnt <= '0;
          end else begin
            dvd      <= dvd_step;
            rem      <= rem_step;
            step_cnt <= step_cnt + 1'b1;
          end
        end
        ST_DIV_Y: begin
          dvd <= dvd_step;
          rem <= rem_step;
          if (step_last) begin
            step_cnt <= '0;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end
        ST_LOAD: begin
          step_cnt <= '0;
        end
        default: step_cnt <= '0;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_LOAD && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && out_free) begin
      centre_x    <= empty_hold ? width_eff[OUT_W:1] : quot_x;
      centre_y    <= empty_hold ? height_eff[OUT_W:1] : dvd[OUT_W-1:0];
      white_total <= divisor;
      empty_frame <= empty_hold;
    end
  end

`ifndef SYNTHESIS
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (empty_frame == (white_total == '0)))
    else $error("empty_frame disagrees with white_total");

  a_accum_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_X || state == ST_DIV_Y)
      |-> (white_seen == '0 && column_pos == '0 && row_pos == '0))
    else $error("accumulators not cleared during division");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_Y) |-> (rem < divisor))
    else $error("divider remainder out of range");

  a_load_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_LOAD))
    else $error("result loaded outside load step");
`endif

endmodule
